/* rtl/core/rbsp_pkg.sv */
// ----------------------------------------------------------------------------
// rbsp_pkg
// Shared constants, codes and types for the ring buffer SPI packetizer.
// ----------------------------------------------------------------------------
package rbsp_pkg;

	localparam int BUFFER_DEPTH = 4096;
	localparam int PACKET_BYTES = 32;
	localparam int FRAME_BYTES  = PACKET_BYTES + 2;

	localparam int ADDR_W  = $clog2(BUFFER_DEPTH);
	localparam int CNT_W   = ADDR_W + 1;
	localparam int CHUNK_W = $clog2(PACKET_BYTES + 1);
	localparam int POS_W   = $clog2(FRAME_BYTES);
	localparam int DATA_W  = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	// input item actions
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_CMD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_ADDR = 2'd1;

	typedef enum logic {
		ST_IDLE,
		ST_STREAM
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// one frame byte in flight between the controller and the output stage
	typedef struct packed {
		logic              valid;
		logic              from_mem;
		logic [DATA_W-1:0] fbyte;
		logic              last;
	} frame_tag_t;

	typedef struct packed {
		logic [1:0] occ;
		logic       pop;
	} out_status_t;

endpackage

/* rtl/core/rbsp_in_if.sv */
// ----------------------------------------------------------------------------
// rbsp_in_if
// Input channel: write one byte or request one drain.
// ----------------------------------------------------------------------------
interface rbsp_in_if;
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic [rbsp_pkg::DATA_W-1:0] data_byte;

	modport source (output valid, action, data_byte, input ready);
	modport sink   (input valid, action, data_byte, output ready);
endinterface

/* rtl/core/rbsp_out_if.sv */
// ----------------------------------------------------------------------------
// rbsp_out_if
// Output channel: one SPI frame byte per item.
// ----------------------------------------------------------------------------
interface rbsp_out_if;
	logic                      valid;
	logic                      ready;
	logic [rbsp_pkg::DATA_W-1:0] frame_byte;
	logic                      frame_last;

	modport source (output valid, frame_byte, frame_last, input ready);
	modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

/* rtl/core/rbsp_store.sv */
// ----------------------------------------------------------------------------
// rbsp_store
// Byte store of the ring buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rbsp_store (
	input  logic                          clk,
	input  rbsp_pkg::mem_req_t            req,
	output logic [rbsp_pkg::DATA_W-1:0]   rdata
);

	logic [rbsp_pkg::DATA_W-1:0] mem [rbsp_pkg::BUFFER_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

/* rtl/core/rbsp_out_stage.sv */
// ----------------------------------------------------------------------------
// rbsp_out_stage
// Two-entry output queue; merges store read data into the frame stream.
// ----------------------------------------------------------------------------
module rbsp_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rbsp_pkg::frame_tag_t          tag,
	input  logic [rbsp_pkg::DATA_W-1:0]   rdata,
	output rbsp_pkg::out_status_t         status,
	rbsp_out_if.source                    frame_out
);

	logic [rbsp_pkg::DATA_W-1:0] fbyte_q [2];
	logic                        last_q [2];
	logic                        wr_ptr_q;
	logic                        rd_ptr_q;
	logic [1:0]                  occ_q;
	logic                        push;
	logic                        pop;
	logic [rbsp_pkg::DATA_W-1:0] push_byte;

	assign push      = tag.valid;
	assign pop       = frame_out.valid & frame_out.ready;
	assign push_byte = tag.from_mem ? rdata : tag.fbyte;

	assign frame_out.valid      = (occ_q != 2'd0);
	assign frame_out.frame_byte = fbyte_q[rd_ptr_q];
	assign frame_out.frame_last = last_q[rd_ptr_q];

	assign status.occ = occ_q;
	assign status.pop = pop;

	always_ff @(posedge clk) begin
		if (push) begin
			fbyte_q[wr_ptr_q] <= push_byte;
			last_q[wr_ptr_q]  <= tag.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			occ_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   occ_q <= occ_q + 2'd1;
				2'b01:   occ_q <= occ_q - 2'd1;
				default: occ_q <= occ_q;
			endcase
		end
	end

endmodule

/* rtl/core/rbsp_ctrl.sv */
// ----------------------------------------------------------------------------
// rbsp_ctrl
// Pointer and count keeping, chunk sizing and frame byte sequencing.
// ----------------------------------------------------------------------------
module rbsp_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	rbsp_in_if.sink                           item_in,
	input  logic                              cfg_we,
	input  logic [rbsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rbsp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  rbsp_pkg::out_status_t             status,
	output rbsp_pkg::mem_req_t                req,
	output rbsp_pkg::frame_tag_t              tag_s1
);

	localparam int ADDR_W  = rbsp_pkg::ADDR_W;
	localparam int CNT_W   = rbsp_pkg::CNT_W;
	localparam int CHUNK_W = rbsp_pkg::CHUNK_W;
	localparam int POS_W   = rbsp_pkg::POS_W;

	rbsp_pkg::state_t state_q, state_d;

	logic [ADDR_W-1:0]           rp_q;
	logic [ADDR_W-1:0]           wp_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [CHUNK_W-1:0]          chunk_q;
	logic [POS_W-1:0]            pos_q;
	logic [rbsp_pkg::DATA_W-1:0] cmd_q;
	logic [rbsp_pkg::DATA_W-1:0] addr_q;

	logic                        accept;
	logic                        do_write;
	logic                        do_drain;
	logic                        issue;
	logic                        last_pos;
	logic [2:0]                  load;
	logic [CNT_W-1:0]            room;
	logic [CNT_W-1:0]            lim;
	logic [CHUNK_W-1:0]          chunk_d;
	logic [ADDR_W-1:0]           wp_nx;
	logic [POS_W-1:0]            offs;
	logic                        in_chunk;
	rbsp_pkg::frame_tag_t        tag_d;

	assign accept   = item_in.valid & item_in.ready;
	assign do_write = accept & (item_in.action == rbsp_pkg::ACT_WRITE);
	assign do_drain = accept & (item_in.action == rbsp_pkg::ACT_DRAIN)
	                  & (cnt_q != '0);
	assign wp_nx    = wp_q + ADDR_W'(1);

	// chunk = min(count, bytes before wrap, packet size)
	assign room    = CNT_W'(rbsp_pkg::BUFFER_DEPTH) - {1'b0, rp_q};
	assign lim     = (cnt_q < room) ? cnt_q : room;
	assign chunk_d = (lim > CNT_W'(rbsp_pkg::PACKET_BYTES))
	                 ? CHUNK_W'(rbsp_pkg::PACKET_BYTES) : lim[CHUNK_W-1:0];

	// keep in-flight plus queued bytes within the two output slots
	assign load     = {1'b0, status.occ} + {2'b00, tag_s1.valid};
	assign last_pos = (pos_q == POS_W'(rbsp_pkg::FRAME_BYTES - 1));
	assign offs     = pos_q - POS_W'(2);
	assign in_chunk = (pos_q >= POS_W'(2)) && (offs < POS_W'(chunk_q));

	always_comb begin
		state_d       = state_q;
		item_in.ready = 1'b0;
		issue         = 1'b0;
		req.we        = do_write;
		req.waddr     = wp_q;
		req.wdata     = item_in.data_byte;
		req.re        = 1'b0;
		req.raddr     = rp_q + ADDR_W'(offs);
		tag_d.valid    = 1'b0;
		tag_d.from_mem = in_chunk;
		tag_d.last     = last_pos;
		tag_d.fbyte    = '0;
		case (pos_q)
			POS_W'(0): tag_d.fbyte = cmd_q;
			POS_W'(1): tag_d.fbyte = addr_q;
			default:   tag_d.fbyte = '0;
		endcase
		case (state_q)
			rbsp_pkg::ST_IDLE: begin
				item_in.ready = 1'b1;
				if (do_drain) begin
					state_d = rbsp_pkg::ST_STREAM;
				end
			end
			rbsp_pkg::ST_STREAM: begin
				issue = (load < (3'd2 + {2'b00, status.pop}));
				if (issue) begin
					tag_d.valid = 1'b1;
					req.re      = in_chunk;
					if (last_pos) begin
						state_d = rbsp_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = rbsp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbsp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			cnt_q  <= '0;
			pos_q  <= '0;
			cmd_q  <= '0;
			addr_q <= '0;
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_d;
			if (cfg_we) begin
				case (cfg_index)
					rbsp_pkg::REG_WRITE_CMD: cmd_q  <= cfg_data;
					rbsp_pkg::REG_DATA_ADDR: addr_q <= cfg_data;
					default: ;
				endcase
			end
			if (do_write) begin
				wp_q <= wp_nx;
				// full: oldest byte is overwritten, read side follows
				if (cnt_q == CNT_W'(rbsp_pkg::BUFFER_DEPTH)) begin
					rp_q <= wp_nx;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (do_drain) begin
				pos_q <= '0;
			end else if (issue) begin
				pos_q <= pos_q + POS_W'(1);
				if (last_pos) begin
					rp_q  <= rp_q + ADDR_W'(chunk_q);
					cnt_q <= cnt_q - CNT_W'(chunk_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_drain) begin
			chunk_q <= chunk_d;
		end
	end

endmodule

/* rtl/core/ring_buffer_spi_packetizer.sv */
// ----------------------------------------------------------------------------
// ring_buffer_spi_packetizer
// Transmit ring buffer with overwrite-oldest and fixed-length SPI framing.
// ----------------------------------------------------------------------------
// A byte write leaves the block idle and the next item is accepted in the
// following cycle; a drain of an empty buffer also leaves it idle. A drain
// with data held emits a 34-byte frame (command, address, up to 32 stored
// bytes that never cross the end of the store, zero padding) at one byte per
// cycle while the output takes them; the input stays closed until the last
// frame byte is issued, stalls included, and the last frame bytes drain from a
// two-entry output queue while the next item is already taken. The store
// needs no clearing pass after reset. The user must write configuration
// registers only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module ring_buffer_spi_packetizer (
	input  logic                              clk,
	input  logic                              arst_n,
	rbsp_in_if.sink                           item_in,
	rbsp_out_if.source                        frame_out,
	input  logic                              cfg_we,
	input  logic [rbsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rbsp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	rbsp_pkg::mem_req_t          req;
	rbsp_pkg::frame_tag_t        tag_s1;
	rbsp_pkg::out_status_t       status;
	logic [rbsp_pkg::DATA_W-1:0] rdata;

	rbsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (item_in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.req       (req),
		.tag_s1    (tag_s1)
	);

	rbsp_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	rbsp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag       (tag_s1),
		.rdata     (rdata),
		.status    (status),
		.frame_out (frame_out)
	);

endmodule
